[src/mchull_pkg.sv]
// shared constants, types and status codes of the hull line store
// no dependencies
package mchull_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int SLOPE_W   = 32;
  localparam int ICPT_W    = 63;
  localparam int VALUE_W   = 64;
  localparam int COUNT_W   = 11;
  localparam int STATUS_W  = 2;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic cap0;
    logic cap1;
    logic shift;
    logic diff;
    logic norm;
    logic mul;
    logic sum;
  } mchull_ctl_t;

endpackage

[src/mchull_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module mchull_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/mchull_eval.sv]
// line registers and staged arithmetic: intersection cross-multiply and line values
// depends on mchull_pkg
module mchull_eval (
  input  logic                                 clk,
  input  mchull_pkg::mchull_ctl_t              ctl,
  input  logic                                 is_query,
  input  logic signed [mchull_pkg::SLOPE_W-1:0] q_slope,
  input  logic signed [mchull_pkg::ICPT_W-1:0]  q_icpt,
  input  logic signed [mchull_pkg::SLOPE_W-1:0] new_slope,
  input  logic signed [mchull_pkg::ICPT_W-1:0]  new_icpt,
  input  logic signed [mchull_pkg::SLOPE_W-1:0] qx,
  output logic                                 pop,
  output logic signed [mchull_pkg::VALUE_W-1:0] v0,
  output logic signed [mchull_pkg::VALUE_W-1:0] v1
);
  import mchull_pkg::*;

  logic signed [SLOPE_W-1:0] s0_r, s1_r;
  logic signed [ICPT_W-1:0]  i0_r, i1_r;
  logic signed [63:0] n1_r, n2_r;
  logic signed [32:0] d1_r, d2_r;
  logic signed [63:0] nn1_r, nn2_r;
  logic [32:0]        dn1_r, dn2_r;
  logic [64:0]        pl1_r, pl2_r;
  logic signed [65:0] ph1_r, ph2_r;
  logic signed [63:0] qv0_r, qv1_r;
  logic signed [97:0] prod1_r, prod2_r;
  logic signed [63:0] v0_r, v1_r;

  always_ff @(posedge clk) begin
    if (ctl.cap0) begin
      s0_r <= q_slope;
      i0_r <= q_icpt;
    end else if (ctl.shift) begin
      s0_r <= s1_r;
      i0_r <= i1_r;
    end
    if (ctl.cap1) begin
      s1_r <= q_slope;
      i1_r <= q_icpt;
    end
    if (ctl.diff) begin
      n1_r <= 64'(q_icpt) - 64'(new_icpt);
      d1_r <= 33'(new_slope) - 33'(q_slope);
      n2_r <= 64'(q_icpt) - 64'(i0_r);
      d2_r <= 33'(s0_r) - 33'(q_slope);
    end
    if (ctl.norm) begin
      nn1_r <= d1_r[32] ? -n1_r : n1_r;
      dn1_r <= d1_r[32] ? 33'(-d1_r) : 33'(d1_r);
      nn2_r <= d2_r[32] ? -n2_r : n2_r;
      dn2_r <= d2_r[32] ? 33'(-d2_r) : 33'(d2_r);
    end
    if (ctl.mul) begin
      pl1_r <= 65'(nn1_r[31:0]) * 65'(dn2_r);
      ph1_r <= 66'(signed'(nn1_r[63:32])) * 66'(signed'({1'b0, dn2_r}));
      pl2_r <= 65'(nn2_r[31:0]) * 65'(dn1_r);
      ph2_r <= 66'(signed'(nn2_r[63:32])) * 66'(signed'({1'b0, dn1_r}));
      qv0_r <= 64'(s0_r) * 64'(qx);
      qv1_r <= 64'(s1_r) * 64'(qx);
    end
    if (ctl.sum) begin
      prod1_r <= (98'(ph1_r) <<< 32) + signed'(98'(pl1_r));
      prod2_r <= (98'(ph2_r) <<< 32) + signed'(98'(pl2_r));
      v0_r    <= qv0_r + 64'(i0_r);
      v1_r    <= qv1_r + 64'(i1_r);
    end
  end

  assign pop = is_query ? !(v0_r > v1_r) : !(prod1_r < prod2_r);
  assign v0  = v0_r;
  assign v1  = v1_r;

endmodule

[src/monotone_convex_hull_trick_core.sv]
// monotone convex hull trick line store: sequencer, pointers and line memories
// depends on mchull_pkg, mchull_ram, mchull_eval
// a full add or empty query goes straight to done; an add to fewer than
// two lines inserts with no test; each test reads its lines through the
// single read port, then normalises, multiplies, sums and compares
// one transaction at a time; synchronous active-low reset empties the store
module monotone_convex_hull_trick_core #(
  parameter int STORE_DEPTH = mchull_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic signed [mchull_pkg::SLOPE_W-1:0] in_slope,
  input  logic signed [mchull_pkg::ICPT_W-1:0]  in_intercept,
  input  logic signed [mchull_pkg::SLOPE_W-1:0] in_query_x,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mchull_pkg::VALUE_W-1:0] out_best_value,
  output logic [mchull_pkg::STATUS_W-1:0]      out_status,
  output logic [mchull_pkg::COUNT_W-1:0]       out_line_count
);
  import mchull_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_RDN  = 4'd3;
  localparam logic [3:0] S_LDB  = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_INS  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] p);
    return (p == '0) ? LAST : p - AW'(1);
  endfunction

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] front_r, front_nxt, back_r, back_nxt, p1_r, p1_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          mode_r;
  logic signed [SLOPE_W-1:0] xm_r, t_r;
  logic signed [ICPT_W-1:0]  xc_r;
  logic signed [VALUE_W-1:0] res_best_r, res_best_nxt;
  logic [STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_best_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [CW-1:0]             out_count_r;
  logic [31:0]               count32;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic signed [SLOPE_W-1:0] q_slope;
  logic signed [ICPT_W-1:0]  q_icpt;
  mchull_ctl_t   ctl;
  logic          pop;
  logic signed [VALUE_W-1:0] v0, v1;
  logic          accept, load_out;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign raddr    = (state_r == S_RDA) ? ((mode_r == MODE_QUERY) ? back_r : front_r) : p1_r;

  mchull_ram #(.W(SLOPE_W), .D(STORE_DEPTH)) u_slope_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(xm_r), .raddr(raddr), .rdata(q_slope)
  );

  mchull_ram #(.W(ICPT_W), .D(STORE_DEPTH)) u_icpt_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(xc_r), .raddr(raddr), .rdata(q_icpt)
  );

  mchull_eval u_eval (
    .clk(clk), .ctl(ctl), .is_query(mode_r), .q_slope(q_slope), .q_icpt(q_icpt),
    .new_slope(xm_r), .new_icpt(xc_r), .qx(t_r), .pop(pop), .v0(v0), .v1(v1)
  );

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    p1_nxt         = p1_r;
    held_nxt       = held_r;
    res_best_nxt   = res_best_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ctl            = '0;
    we             = 1'b0;
    waddr          = front_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_best_nxt   = '0;
          res_status_nxt = ST_OK;
          if (in_mode == MODE_ADD) begin
            if (held_r == CW'(STORE_DEPTH)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end else if (held_r < CW'(2)) begin
              state_nxt = S_INS;
            end else begin
              state_nxt = S_RDA;
            end
          end else begin
            if (held_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_RDA;
            end
          end
        end
      end
      S_RDA: begin
        p1_nxt    = (mode_r == MODE_QUERY) ? slot_prev(back_r) : slot_next(front_r);
        state_nxt = S_RDB;
      end
      S_RDB: begin
        ctl.cap0  = 1'b1;
        state_nxt = (held_r < CW'(2)) ? S_MUL : S_LDB;
      end
      S_RDN: begin
        state_nxt = S_LDB;
      end
      S_LDB: begin
        ctl.cap1  = 1'b1;
        ctl.diff  = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        ctl.norm  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        ctl.sum   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (mode_r == MODE_QUERY) begin
          if (held_r >= CW'(2) && pop) begin
            back_nxt = p1_r;
            held_nxt = held_r - CW'(1);
            if (held_r >= CW'(3)) begin
              ctl.shift = 1'b1;
              p1_nxt    = slot_prev(p1_r);
              state_nxt = S_RDN;
            end else begin
              res_best_nxt = v1;
              state_nxt    = S_DONE;
            end
          end else begin
            res_best_nxt = v0;
            state_nxt    = S_DONE;
          end
        end else begin
          if (pop) begin
            front_nxt = p1_r;
            held_nxt  = held_r - CW'(1);
            if (held_r >= CW'(3)) begin
              ctl.shift = 1'b1;
              p1_nxt    = slot_next(p1_r);
              state_nxt = S_RDN;
            end else begin
              state_nxt = S_INS;
            end
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_INS: begin
        we       = 1'b1;
        held_nxt = held_r + CW'(1);
        if (held_r == '0) begin
          back_nxt = front_r;
          waddr    = front_r;
        end else begin
          front_nxt = slot_prev(front_r);
          waddr     = slot_prev(front_r);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r         <= p1_nxt;
    res_best_r   <= res_best_nxt;
    res_status_r <= res_status_nxt;
    if (accept) begin
      mode_r <= in_mode;
      xm_r   <= in_slope;
      xc_r   <= in_intercept;
      t_r    <= in_query_x;
    end
    if (load_out) begin
      out_best_r   <= res_best_r;
      out_status_r <= res_status_r;
      out_count_r  <= held_r;
    end
  end

  assign count32        = 32'(out_count_r);
  assign out_valid      = out_valid_r;
  assign out_best_value = out_best_r;
  assign out_status     = out_status_r;
  assign out_line_count = count32[COUNT_W-1:0];

endmodule
